// ----- rtl/core/suf_pkg.sv -----
// Shared types and constants of the stepper UART datagram framer.
// Used by the front end, the job queue, the back end and the top level.
package suf_pkg;

    localparam int MOTOR_COUNT = 8;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_REPLY = 2'd2;

    localparam logic [7:0] SYNC_BYTE  = 8'h05;
    localparam logic [7:0] WRITE_FLAG = 8'h80;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    typedef enum logic [1:0] {
        K_WRITE,
        K_READ,
        K_ERROR,
        K_REPLY
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        port;
        logic [1:0]  addr;
        logic [7:0]  regaddr;
        logic [31:0] word;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_qslot;

endpackage

// ----- rtl/core/suf_front.sv -----
// Front end: accepts input beats, checks requests and collects reply bytes.
// Pushes one job per result-producing beat into the queue; uses suf_pkg.
module suf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [1:0]     i_action,
    input  logic [7:0]     i_motor_index,
    input  logic [7:0]     i_register_index,
    input  logic [31:0]    i_write_data,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_full,
    output suf_pkg::t_qslot o_push
);
    import suf_pkg::*;

    logic        r_await;
    logic        n_await;
    logic [2:0]  r_count;
    logic [2:0]  n_count;
    logic [31:0] r_shift;
    logic [31:0] n_shift;
    logic        accept;
    logic        bad;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign bad     = (i_motor_index >= 8'(MOTOR_COUNT)) || i_register_index[7];

    always_comb begin
        n_await            = r_await;
        n_count            = r_count;
        n_shift            = r_shift;
        o_push.valid       = 1'b0;
        o_push.job.kind    = K_ERROR;
        o_push.job.port    = i_motor_index[2];
        o_push.job.addr    = i_motor_index[1:0];
        o_push.job.regaddr = i_register_index;
        o_push.job.word    = i_write_data;
        case (i_action)
            ACT_WRITE, ACT_READ: begin
                if (accept) begin
                    o_push.valid = 1'b1;
                    if (!bad) begin
                        o_push.job.kind = (i_action == ACT_WRITE) ? K_WRITE : K_READ;
                        n_await         = (i_action == ACT_READ);
                        n_count         = '0;
                        n_shift         = '0;
                    end
                end
            end
            ACT_REPLY: begin
                if (accept && r_await) begin
                    if (r_count >= 3'd3 && r_count <= 3'd6) begin
                        n_shift = {r_shift[23:0], i_rx_byte};
                    end
                    if (r_count == 3'd7) begin
                        o_push.valid    = 1'b1;
                        o_push.job.kind = K_REPLY;
                        o_push.job.word = r_shift;
                        n_await         = 1'b0;
                        n_count         = '0;
                        n_shift         = '0;
                    end else begin
                        n_count = r_count + 3'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= 1'b0;
            r_count <= '0;
            r_shift <= '0;
        end else begin
            r_await <= n_await;
            r_count <= n_count;
            r_shift <= n_shift;
        end
    end

endmodule

// ----- rtl/core/suf_queue.sv -----
// Short job queue between the front end and the back end.
// Holds QDEPTH jobs in registers; uses suf_pkg.
module suf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  suf_pkg::t_qslot i_push,
    input  logic            i_pop,
    output logic            o_full,
    output suf_pkg::t_qslot o_head
);
    import suf_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QCW-1:0] r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full       = (r_count == QCW'(QDEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rptr];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QAW'(QDEPTH - 1)) ? '0 : r_wptr + QAW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QAW'(QDEPTH - 1)) ? '0 : r_rptr + QAW'(1);
            end
            r_count <= r_count + QCW'(do_push) - QCW'(do_pop);
        end
    end

endmodule

// ----- rtl/core/suf_back.sv -----
// Back end: turns the queue head into result beats, one byte per cycle while
// i_stall is low, with a running CRC-8 and an output register; uses suf_pkg.
module suf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  suf_pkg::t_qslot i_head,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [7:0]      o_tx_byte,
    output logic            o_tx_valid,
    output logic            o_port_select,
    output logic            o_last_byte,
    output logic [31:0]     o_reply_word,
    output logic            o_reply_valid,
    output logic            o_request_error
);
    import suf_pkg::*;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] crc;
        logic [7:0] cur;
        logic       top;
        crc = crc_in;
        cur = data;
        for (int b = 0; b < 8; b++) begin
            top = crc[7];
            crc = {crc[6:0], 1'b0};
            if (top ^ cur[0]) begin
                crc = crc ^ CRC_POLY;
            end
            cur = {1'b0, cur[7:1]};
        end
        return crc;
    endfunction

    logic        r_valid;
    logic [2:0]  r_idx;
    logic [7:0]  r_crc;
    logic [7:0]  r_tx_byte;
    logic        r_tx_valid;
    logic        r_port;
    logic        r_last;
    logic [31:0] r_word;
    logic        r_reply_valid;
    logic        r_error;

    t_job        job;
    logic        is_wr;
    logic        dgram;
    logic [2:0]  last_idx;
    logic [7:0]  crc_in;
    logic [7:0]  n_byte;
    logic        advance;
    logic        fire;
    logic        beat_last;

    assign job       = i_head.job;
    assign is_wr     = (job.kind == K_WRITE);
    assign dgram     = (job.kind == K_WRITE) || (job.kind == K_READ);
    assign last_idx  = is_wr ? 3'd7 : 3'd3;
    assign crc_in    = (r_idx == '0) ? 8'h00 : r_crc;
    assign advance   = !r_valid || !i_stall;
    assign fire      = advance && i_head.valid;
    assign beat_last = !dgram || (r_idx == last_idx);
    assign o_pop     = fire && beat_last;

    always_comb begin
        case (r_idx)
            3'd0:    n_byte = SYNC_BYTE;
            3'd1:    n_byte = {6'b0, job.addr};
            3'd2:    n_byte = is_wr ? (job.regaddr | WRITE_FLAG) : job.regaddr;
            3'd3:    n_byte = is_wr ? job.word[31:24] : crc_in;
            3'd4:    n_byte = job.word[23:16];
            3'd5:    n_byte = job.word[15:8];
            3'd6:    n_byte = job.word[7:0];
            default: n_byte = crc_in;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (advance) begin
                r_valid <= i_head.valid;
            end
            if (fire) begin
                r_idx         <= beat_last ? 3'd0 : r_idx + 3'd1;
                r_crc         <= crc8_step(crc_in, n_byte);
                r_tx_byte     <= dgram ? n_byte : 8'h00;
                r_tx_valid    <= dgram;
                r_port        <= dgram && job.port;
                r_last        <= beat_last;
                r_word        <= (job.kind == K_REPLY) ? job.word : 32'h0;
                r_reply_valid <= (job.kind == K_REPLY);
                r_error       <= (job.kind == K_ERROR);
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_tx_byte       = r_tx_byte;
    assign o_tx_valid      = r_tx_valid;
    assign o_port_select   = r_port;
    assign o_last_byte     = r_last;
    assign o_reply_word    = r_word;
    assign o_reply_valid   = r_reply_valid;
    assign o_request_error = r_error;

    a_mid_datagram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> (i_head.valid && (job.kind == K_WRITE || job.kind == K_READ)))
        else $error("byte index advanced without a datagram at the queue head");

    a_read_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx > 3'd3) |-> (job.kind == K_WRITE))
        else $error("read datagram ran past its CRC byte");

    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (o_valid && o_last_byte))
        else $error("job retired without a final beat in the output register");

endmodule

// ----- rtl/core/stepper_uart_datagram_framer.sv -----
// Top level of the stepper UART datagram framer.
// Connects suf_front, suf_queue and suf_back; uses suf_pkg.
//
// Each accepted beat passes through the front end combinationally; the back end
// sends one result beat per cycle unless the output stalls: eight for a write
// request, four for a read request, one for a rejected request or a completed
// eight-byte reply, none otherwise. A two-entry job queue lets new input beats
// in while a datagram is still going out; the input stalls only when that queue
// is full. An accepted job is written into the job queue, and its first result
// beat is then registered in the back-end output register.
module stepper_uart_datagram_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_motor_index,
    input  logic [7:0]  i_register_index,
    input  logic [31:0] i_write_data,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_valid,
    output logic        o_port_select,
    output logic        o_last_byte,
    output logic [31:0] o_reply_word,
    output logic        o_reply_valid,
    output logic        o_request_error
);
    import suf_pkg::*;

    t_qslot push;
    t_qslot head;
    logic   full;
    logic   pop;

    suf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_action         (i_action),
        .i_motor_index    (i_motor_index),
        .i_register_index (i_register_index),
        .i_write_data     (i_write_data),
        .i_rx_byte        (i_rx_byte),
        .i_full           (full),
        .o_push           (push)
    );

    suf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    suf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_tx_byte       (o_tx_byte),
        .o_tx_valid      (o_tx_valid),
        .o_port_select   (o_port_select),
        .o_last_byte     (o_last_byte),
        .o_reply_word    (o_reply_word),
        .o_reply_valid   (o_reply_valid),
        .o_request_error (o_request_error)
    );

endmodule
